/* src/nsp_pkg.sv */
// ----------------------------------------------------------------------------
// nsp_pkg
// Shared types and constants of the note sequence player.
// ----------------------------------------------------------------------------
`default_nettype none

package nsp_pkg;

    // Command codes carried in the cmd field of an input item.
    localparam logic [2:0] CMD_WRITE = 3'd0;
    localparam logic [2:0] CMD_PLAY  = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_TICK  = 3'd3;
    localparam logic [2:0] CMD_QUERY = 3'd4;

    // One stored note: wave, frequency, volume and duration in ms.
    localparam int unsigned NOTE_W = 48;

    // Duration conversion constants. The divide by 1000 is a shift by three
    // followed by a multiply with ceil(2^37 / 125), which is exact for every
    // 30-bit dividend. SAT_LIMIT is 1000 * 2^23.
    localparam logic [30:0] DIV125_MUL = 31'd1099511628;
    localparam logic [22:0] LEFT_MAX   = 23'h7F_FFFF;
    localparam logic [32:0] SAT_LIMIT  = 33'd8388608000;
    localparam logic [16:0] RATE_RST   = 17'd48000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        logic ram_wr;
        logic ram_rd;
        logic play_set;
        logic stop_sel;
        logic sel_zero;
        logic sel_inc;
        logic consume;
        logic left_sub;
        logic load_set;
        logic left_load;
        logic emit;
        logic emit_last;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] cmd;
        logic       v_ok;
        logic       cnt_nz;
        logic       is_tick;
        logic       active;
        logic       rem_ge;
        logic       idx_end;
        logic       sel_last;
        logic       rep_last;
        logic       dur_done;
        logic       out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

/* src/nsp_ram.sv */
// ----------------------------------------------------------------------------
// nsp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module nsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* src/nsp_dur.sv */
// ----------------------------------------------------------------------------
// nsp_dur
// Converts a note duration in ms to samples: ms*rate/1000, saturated, at
// least one. The product ms*rate is registered first, then the divide by
// 1000, done through a shift and a reciprocal multiply, is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module nsp_dur
    import nsp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [15:0] i_ms,
    input  wire logic [16:0] i_rate,
    output logic             o_done,
    output logic [22:0]      o_samples
);

    logic [32:0] r_prod;
    logic [22:0] r_q;
    logic        r_step;
    logic        r_sat;
    logic        r_done;
    logic [60:0] scaled;

    // Product divided by 8, times ceil(2^37 / 125); the quotient by 1000
    // sits from bit 37 up. Only the unsaturated range is taken from it.
    assign scaled = 61'(r_prod[32:3]) * 61'(DIV125_MUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_step <= i_start;
            if (i_start) begin
                r_prod <= 33'(i_ms) * 33'(i_rate);
            end
            if (r_step) begin
                r_sat  <= (r_prod >= SAT_LIMIT);
                r_q    <= scaled[59:37];
                r_done <= 1'b1;
            end
        end
    end

    assign o_done    = r_done;
    assign o_samples = r_sat ? LEFT_MAX : ((r_q == '0) ? 23'd1 : r_q);

endmodule

`default_nettype wire

/* src/nsp_dp.sv */
// ----------------------------------------------------------------------------
// nsp_dp
// Datapath: input latch, note store, voice state, duration unit and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module nsp_dp
    import nsp_pkg::*;
#(
    parameter int NOTE_DEPTH = 256,
    parameter int VOICES     = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_dp_cmd     i_cmd,
    output t_dp_stat         o_stat,
    input  wire logic [87:0] i_in_data,
    input  wire logic        i_cfg_valid,
    input  wire logic [16:0] i_cfg_data,
    input  wire logic        i_out_ready,
    output logic             o_out_valid,
    output logic [39:0]      o_out_data,
    output logic             o_out_last
);

    localparam int AW = $clog2(NOTE_DEPTH);
    localparam int SW = (VOICES > 4) ? 3 : 2;
    localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int NREP = (VOICES < 4) ? VOICES : 4;
    localparam logic [SW:0]   VCNT     = (SW + 1)'(VOICES);
    localparam logic [SW-1:0] SEL_LAST = SW'(VOICES - 1);
    localparam logic [SW-1:0] REP_LAST = SW'(NREP - 1);

    // Latched input item.
    logic [2:0]  r_cmd;
    logic [1:0]  r_v;
    logic [7:0]  r_addr;
    logic [8:0]  r_cnt;
    logic [7:0]  r_nwave;
    logic [15:0] r_nfreq;
    logic [7:0]  r_nvol;
    logic [15:0] r_nms;
    logic [15:0] r_tick;

    logic [16:0]   r_rate;
    logic [SW-1:0] r_sel;
    logic [15:0]   r_rem;

    // Per-voice state.
    logic [7:0]  r_start [VOICES];
    logic [8:0]  r_count [VOICES];
    logic [8:0]  r_index [VOICES];
    logic [22:0] r_left  [VOICES];
    logic        r_act   [VOICES];
    logic [7:0]  r_wave  [VOICES];
    logic [15:0] r_freq  [VOICES];
    logic [7:0]  r_vol   [VOICES];

    logic        r_ovalid;
    logic [39:0] r_odata;
    logic        r_olast;

    logic [IW-1:0]     ix;
    logic              sel_ok;
    logic [NOTE_W-1:0] rd_note;
    logic [9:0]        rd_sum;
    logic              dur_done;
    logic [22:0]       dur_samples;

    assign ix     = r_sel[IW-1:0];
    assign sel_ok = ({1'b0, r_sel} < VCNT);
    assign rd_sum = 10'(r_start[ix]) + 10'(r_index[ix]);

    nsp_ram #(
        .WIDTH (NOTE_W),
        .DEPTH (NOTE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ram_wr),
        .i_waddr (AW'(r_addr)),
        .i_wdata ({r_nms, r_nvol, r_nfreq, r_nwave}),
        .i_re    (i_cmd.ram_rd),
        .i_raddr (AW'(rd_sum)),
        .o_rdata (rd_note)
    );

    nsp_dur u_dur (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.load_set),
        .i_ms      (rd_note[47:32]),
        .i_rate    (r_rate),
        .o_done    (dur_done),
        .o_samples (dur_samples)
    );

    // Register updates driven by controller commands.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate   <= RATE_RST;
            r_sel    <= '0;
            r_ovalid <= 1'b0;
            for (int k = 0; k < VOICES; k++) begin
                r_start[k] <= '0;
                r_count[k] <= '0;
                r_index[k] <= '0;
                r_left[k]  <= '0;
                r_act[k]   <= 1'b0;
                r_wave[k]  <= '0;
                r_freq[k]  <= '0;
                r_vol[k]   <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_rate <= i_cfg_data;
            end
            if (i_cmd.latch) begin
                r_cmd   <= i_in_data[2:0];
                r_v     <= i_in_data[4:3];
                r_addr  <= i_in_data[12:5];
                r_cnt   <= i_in_data[21:13];
                r_nwave <= i_in_data[29:22];
                r_nfreq <= i_in_data[45:30];
                r_nvol  <= i_in_data[53:46];
                r_nms   <= i_in_data[69:54];
                r_tick  <= i_in_data[85:70];
                r_sel   <= SW'(i_in_data[4:3]);
            end
            // Each voice starts from its own copy of the tick count.
            if (i_cmd.sel_zero) begin
                r_sel <= '0;
                r_rem <= r_tick;
            end
            if (i_cmd.sel_inc) begin
                r_sel <= r_sel + SW'(1);
                r_rem <= r_tick;
            end
            if (i_cmd.play_set) begin
                r_start[ix] <= r_addr;
                r_count[ix] <= r_cnt;
                r_index[ix] <= '0;
                r_act[ix]   <= 1'b1;
            end
            if (i_cmd.stop_sel) begin
                r_start[ix] <= '0;
                r_count[ix] <= '0;
                r_index[ix] <= '0;
                r_left[ix]  <= '0;
                r_act[ix]   <= 1'b0;
                r_freq[ix]  <= '0;
                r_vol[ix]   <= '0;
            end
            if (i_cmd.consume) begin
                r_rem       <= r_rem - r_left[ix][15:0];
                r_index[ix] <= r_index[ix] + 9'd1;
            end
            if (i_cmd.left_sub) begin
                r_left[ix] <= r_left[ix] - 23'(r_rem);
            end
            // A silent note zeroes frequency and volume but keeps the wave.
            if (i_cmd.load_set) begin
                r_wave[ix] <= rd_note[7:0];
                if (rd_note[23:8] == '0 || rd_note[31:24] == '0) begin
                    r_freq[ix] <= '0;
                    r_vol[ix]  <= '0;
                end else begin
                    r_freq[ix] <= rd_note[23:8];
                    r_vol[ix]  <= rd_note[31:24];
                end
            end
            if (i_cmd.left_load) begin
                r_left[ix] <= dur_samples;
            end
            // Output register.
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
                r_olast  <= i_cmd.emit_last;
                if (sel_ok) begin
                    r_odata <= {5'd0, r_act[ix], r_vol[ix], r_freq[ix], r_wave[ix],
                                r_sel[1:0]};
                end else begin
                    r_odata <= {38'd0, r_sel[1:0]};
                end
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Status toward the controller.
    always_comb begin
        o_stat.cmd      = r_cmd;
        o_stat.v_ok     = sel_ok;
        o_stat.cnt_nz   = (r_cnt != '0);
        o_stat.is_tick  = (r_cmd == CMD_TICK);
        o_stat.active   = sel_ok && r_act[ix];
        o_stat.rem_ge   = (23'(r_rem) >= r_left[ix]);
        o_stat.idx_end  = ((10'(r_index[ix]) + 10'd1) >= 10'(r_count[ix]));
        o_stat.sel_last = (r_sel == SEL_LAST);
        o_stat.rep_last = (r_sel == REP_LAST);
        o_stat.dur_done = dur_done;
        o_stat.out_free = !r_ovalid || i_out_ready;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;
    assign o_out_last  = r_olast;

endmodule

`default_nettype wire

/* src/nsp_ctrl.sv */
// ----------------------------------------------------------------------------
// nsp_ctrl
// Controller state machine that sequences commands, note loads, the tick
// walk over the voices and the results.
// ----------------------------------------------------------------------------
`default_nettype none

module nsp_ctrl
    import nsp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_DEC   = 8'b0000_0010,
        S_RD    = 8'b0000_0100,
        S_LOAD  = 8'b0000_1000,
        S_DUR   = 8'b0001_0000,
        S_TCHK  = 8'b0010_0000,
        S_EMIT  = 8'b0100_0000,
        S_TEMIT = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DEC;
                end
            end
            S_DEC: begin
                unique case (i_stat.cmd)
                    CMD_WRITE: begin
                        o_cmd.ram_wr = 1'b1;
                        n_state      = S_IDLE;
                    end
                    CMD_PLAY: begin
                        if (i_stat.v_ok && i_stat.cnt_nz) begin
                            o_cmd.play_set = 1'b1;
                            n_state        = S_RD;
                        end else begin
                            n_state = S_EMIT;
                        end
                    end
                    CMD_STOP: begin
                        o_cmd.stop_sel = i_stat.v_ok;
                        n_state        = S_EMIT;
                    end
                    CMD_TICK: begin
                        o_cmd.sel_zero = 1'b1;
                        n_state        = S_TCHK;
                    end
                    CMD_QUERY: begin
                        n_state = S_EMIT;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_RD: begin
                o_cmd.ram_rd = 1'b1;
                n_state      = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load_set = 1'b1;
                n_state        = S_DUR;
            end
            S_DUR: begin
                if (i_stat.dur_done) begin
                    o_cmd.left_load = 1'b1;
                    n_state         = i_stat.is_tick ? S_TCHK : S_EMIT;
                end
            end
            S_TCHK: begin
                // Step the selected voice; when spent, load next note or stop.
                if (i_stat.active && i_stat.rem_ge && !i_stat.idx_end) begin
                    o_cmd.consume = 1'b1;
                    n_state       = S_RD;
                end else begin
                    if (i_stat.active && i_stat.rem_ge) begin
                        o_cmd.stop_sel = 1'b1;
                    end else if (i_stat.active) begin
                        o_cmd.left_sub = 1'b1;
                    end
                    if (i_stat.sel_last) begin
                        o_cmd.sel_zero = 1'b1;
                        n_state        = S_TEMIT;
                    end else begin
                        o_cmd.sel_inc = 1'b1;
                    end
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_TEMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = i_stat.rep_last;
                    if (i_stat.rep_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.sel_inc = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/note_sequence_player.sv */
// ----------------------------------------------------------------------------
// note_sequence_player
// Multi-voice sound-effect sequencer with a shared note store.
//
// Channel   Direction  Contents
// s_axis    in         command item: cmd, voice, address, count, note, tick
// m_axis    out        voice report: voice, wave, freq, vol, busy; tlast
// cfg       in         sample rate register (17 bits)
//
// A note write goes back to idle after decode; a query, a stop or an ignored
// play emits one result. A play that starts a voice first loads its note:
// the store is read, the note registered, ms multiplied by rate, and a
// reciprocal multiply does the divide by 1000. A tick checks each voice,
// loads a note for each note stepped and emits one result per voice reported.
// Results wait in an output register; a stalled m_axis holds the controller
// at its next result. Reset is synchronous, active low, and stops every voice.
// ----------------------------------------------------------------------------
`default_nettype none

module note_sequence_player
    import nsp_pkg::*;
#(
    parameter int NOTE_DEPTH = 256,
    parameter int VOICES     = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // cmd, voice, address, note_count, note_wave, note_freq, note_vol,
    // note_ms, tick_samples
    input  wire logic [87:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // out_voice, out_wave, out_freq, out_vol, busy_res
    output logic      [39:0] m_axis_tdata,
    output logic             m_axis_tlast,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [16:0] i_cfg_data
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    assign o_cfg_ready = 1'b1;

    nsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    nsp_dp #(
        .NOTE_DEPTH (NOTE_DEPTH),
        .VOICES     (VOICES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_in_data   (s_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

/* src/nsp_checker.sv */
// ----------------------------------------------------------------------------
// nsp_checker
// Port-level checks of the note sequence player, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module nsp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);

    // A stalled result holds its payload.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // No result is shown in the cycle after reset.
    assert property (@(posedge i_clk) !$past(i_rst_n) |-> !m_axis_tvalid)
        else $error("result after reset");

    // A voice that is not busy is silent.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[34] |->
            m_axis_tdata[25:10] == 16'd0 && m_axis_tdata[33:26] == 8'd0)
        else $error("idle voice not silent");

    // Frequency and volume are zero together.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[25:10] == 16'd0) == (m_axis_tdata[33:26] == 8'd0))
        else $error("half-silent voice");

endmodule

bind note_sequence_player nsp_checker u_nsp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
